// ----- rtl/core/iprc_pkg.sv -----
package iprc_pkg;

   // Configuration register indexes
   localparam logic [7:0] CSR_SOURCE_PORT    = 8'd0;
   localparam logic [7:0] CSR_BASE_DEST_PORT = 8'd1;

   // Register reset values
   localparam logic [15:0] SOURCE_PORT_RESET    = 16'd32768;
   localparam logic [15:0] BASE_DEST_PORT_RESET = 16'd33434;

   // Protocol constants
   localparam int unsigned ICMP_HDR_BYTES   = 8;
   localparam int unsigned MIN_IP_HDR_BYTES = 20;
   localparam int unsigned UDP_PORT_BYTES   = 4;
   localparam int unsigned PROTO_OFFSET     = 9;

   localparam logic [7:0] PROTO_UDP             = 8'd17;
   localparam logic [7:0] TYPE_TIME_EXCEEDED    = 8'd11;
   localparam logic [7:0] CODE_IN_TRANSIT       = 8'd0;
   localparam logic [7:0] TYPE_UNREACHABLE      = 8'd3;
   localparam logic [7:0] CODE_PORT_UNREACHABLE = 8'd3;

   typedef enum logic [1:0] {
      VERDICT_IGNORED     = 2'd0,
      VERDICT_TIME_EXCEED = 2'd1,
      VERDICT_PORT_UNREACH = 2'd2,
      VERDICT_OTHER_UNREACH = 2'd3
   } verdict_type;

endpackage

// ----- rtl/core/icmp_probe_reply_classifier.sv -----
// ICMP probe reply classifier for a UDP traceroute over IPv4.
//
// req_ channel: one byte of a received IPv4 packet per item, tlast on the
// final byte; tdata also carries the outstanding probe sequence, which is
// sampled on the first byte of each packet.
// rsp_ channel: exactly one item per packet, produced from the final byte:
// tuser holds the verdict, tdata the ICMP code for "other unreachable".
// csr_ channel: register writes (source port, base destination port),
// always ready; write only while no packet is in flight.
//
// Throughput is one byte per clock. The parse state registers take each
// byte as it is accepted, and the verdict is formed in the same cycle into
// the result register, so a result appears in the cycle after its final byte.
// A new byte is taken whenever the result register is empty or being
// drained; while a result waits on a stalled receiver, req_tready is low.
// Reset clears the parse state, empties the result register and loads the
// registers with their default ports (32768 and 33434).
module icmp_probe_reply_classifier
   import iprc_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] packet_byte, [23:8] probe_sequence
   input  logic        req_tlast,   // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] unreachable_code
   output logic [1:0]  rsp_tuser,   // [1:0] verdict
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);
   localparam int unsigned CmpW = (CntW > 9) ? CntW : 9;

   // Registers
   logic [15:0]     src_port_ff;
   logic [15:0]     base_port_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [5:0]      ohb_ff, ohb_in;
   logic [7:0]      type_ff, type_in;
   logic [7:0]      code_ff, code_in;
   logic [5:0]      ihb_ff, ihb_in;
   logic [7:0]      proto_ff, proto_in;
   logic [31:0]     ports_ff, ports_in;
   logic [15:0]     exp_port_ff, exp_port_in;
   logic            rsp_valid_ff;
   logic [1:0]      rsp_verdict_ff;
   logic [7:0]      rsp_code_ff;

   logic [7:0]      pkt_byte;
   logic [15:0]     probe_seq;
   logic            req_fire;
   logic            keep;
   logic [CmpW-1:0] pos;
   logic [CmpW-1:0] inner_at;
   logic [CmpW-1:0] ports_at;
   logic [CmpW-1:0] n_bytes;
   logic            exceeded;
   logic            unreach;
   logic            ours;
   logic            long_enough;
   verdict_type     verdict;
   logic [7:0]      out_code;

   assign pkt_byte  = req_tdata[7:0];
   assign probe_seq = req_tdata[23:8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Take one byte into the parse state
   always_comb begin
      keep        = count_ff < CntW'(MAX_PACKET_BYTES);
      pos         = CmpW'(count_ff);
      count_in    = keep ? count_ff + CntW'(1) : count_ff;
      exp_port_in = (count_ff == '0) ? base_port_ff + probe_seq : exp_port_ff;

      ohb_in   = ohb_ff;
      type_in  = type_ff;
      code_in  = code_ff;
      ihb_in   = ihb_ff;
      proto_in = proto_ff;
      ports_in = ports_ff;

      if (keep && count_ff == '0) begin
         ohb_in = {pkt_byte[3:0], 2'b00};
      end
      if (keep && pos == CmpW'(ohb_in)) begin
         type_in = pkt_byte;
      end
      if (keep && pos == CmpW'(ohb_in) + CmpW'(1)) begin
         code_in = pkt_byte;
      end
      inner_at = CmpW'(ohb_in) + CmpW'(ICMP_HDR_BYTES);
      if (keep && pos == inner_at) begin
         ihb_in = {pkt_byte[3:0], 2'b00};
      end
      if (keep && pos == inner_at + CmpW'(PROTO_OFFSET)) begin
         proto_in = pkt_byte;
      end
      ports_at = inner_at + CmpW'(ihb_in);
      if (keep && pos >= ports_at && pos < ports_at + CmpW'(UDP_PORT_BYTES)) begin
         ports_in = {ports_ff[23:0], pkt_byte};
      end
   end

   // Classify the packet from the state after its final byte
   always_comb begin
      n_bytes  = CmpW'(count_in);
      exceeded = (type_in == TYPE_TIME_EXCEEDED) && (code_in == CODE_IN_TRANSIT);
      unreach  = (type_in == TYPE_UNREACHABLE);
      long_enough =
         (n_bytes >= CmpW'(ohb_in) + CmpW'(ICMP_HDR_BYTES + MIN_IP_HDR_BYTES)) &&
         (n_bytes >= CmpW'(ohb_in) + CmpW'(ihb_in) +
                     CmpW'(ICMP_HDR_BYTES + UDP_PORT_BYTES));
      ours = (proto_in == PROTO_UDP) && (ports_in[31:16] == src_port_ff) &&
             (ports_in[15:0] == exp_port_in);
      verdict  = VERDICT_IGNORED;
      out_code = 8'd0;
      if (long_enough && ours) begin
         if (exceeded) begin
            verdict = VERDICT_TIME_EXCEED;
         end else if (unreach && code_in == CODE_PORT_UNREACHABLE) begin
            verdict = VERDICT_PORT_UNREACH;
         end else if (unreach) begin
            verdict  = VERDICT_OTHER_UNREACH;
            out_code = code_in;
         end
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_port_ff  <= SOURCE_PORT_RESET;
         base_port_ff <= BASE_DEST_PORT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE_PORT:    src_port_ff  <= csr_wdata;
            CSR_BASE_DEST_PORT: base_port_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Parse state: advance on each byte, clear after the final one
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ohb_ff      <= '0;
         type_ff     <= '0;
         code_ff     <= '0;
         ihb_ff      <= '0;
         proto_ff    <= '0;
         ports_ff    <= '0;
         exp_port_ff <= '0;
      end else if (req_fire) begin
         if (req_tlast) begin
            count_ff    <= '0;
            ohb_ff      <= '0;
            type_ff     <= '0;
            code_ff     <= '0;
            ihb_ff      <= '0;
            proto_ff    <= '0;
            ports_ff    <= '0;
            exp_port_ff <= '0;
         end else begin
            count_ff    <= count_in;
            ohb_ff      <= ohb_in;
            type_ff     <= type_in;
            code_ff     <= code_in;
            ihb_ff      <= ihb_in;
            proto_ff    <= proto_in;
            ports_ff    <= ports_in;
            exp_port_ff <= exp_port_in;
         end
      end
   end

   // Result register: load on the final byte, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         rsp_verdict_ff <= verdict;
         rsp_code_ff    <= out_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_verdict_ff;
   assign rsp_tdata  = rsp_code_ff;

endmodule

// ----- rtl/core/iprc_checker.sv -----
module iprc_checker
   import iprc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic final_fire;
   assign final_fire = req_tvalid && req_tready && req_tlast;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser) && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Code is nonzero only for other unreachable
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != VERDICT_OTHER_UNREACH |-> rsp_tdata == 8'd0)
      else $error("code set on a verdict that carries none");

   // A final byte always yields a result next cycle
   a_final_result: assert property (@(posedge clock) disable iff (reset)
      final_fire |=> rsp_tvalid)
      else $error("final byte gave no result");

   // No result without a final byte
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !final_fire && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result without a final byte");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind icmp_probe_reply_classifier iprc_checker u_iprc_checker (.*);
